### hdl/rgb_hsv_pixel_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// rgb/hsv converter assertion macros
// shared check forms for the converter, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef RGB_HSV_PIXEL_CONVERTER_UNIT_DEFINES_SVH
`define RGB_HSV_PIXEL_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication
`define RHC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// types and constants shared by the rgb/hsv converter pipeline
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int PIX_W = 8;

  // hue bases in degrees for each choice of minimum channel
  localparam logic [9:0] HUE_BASE_B = 10'd60;
  localparam logic [9:0] HUE_BASE_R = 10'd180;
  localparam logic [9:0] HUE_BASE_G = 10'd300;
  localparam logic [9:0] HUE_FULL   = 10'd360;
  localparam logic [7:0] HUE_HALF_MAX = 8'd180;

  // width of one reverse sector in half degrees
  localparam int SECT_W = 30;
  localparam logic [3:0] SECT_CNT = 4'd6;

  typedef enum logic [1:0] {
    HSEL_B,
    HSEL_R,
    HSEL_G
  } hsel_t;

  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic             dir;
    // forward
    logic             gray;
    hsel_t            hsel;
    logic             neg;
    logic [PIX_W-1:0] mx;
    logic [15:0]      hn;
    logic [15:0]      sn;
    logic [PIX_W-1:0] hd;
    logic [PIX_W-1:0] sd;
    div_t             hdv;
    div_t             sdv;
    // reverse
    logic [3:0]       sector;
    logic [4:0]       rem30;
    logic             sat0;
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] vs;
    logic [PIX_W-1:0] f;
    logic [PIX_W-1:0] part;
    logic [PIX_W-1:0] rr;
    logic [PIX_W-1:0] gg;
    logic [PIX_W-1:0] bb;
  } pl_t;

  typedef struct packed {
    logic             dir;
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic [PIX_W-1:0] third;
  } out_t;

endpackage

### hdl/rgb_hsv_pixel_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_hsv_pixel_converter_unit
// 8-bit pixel converter, RGB to HSV or HSV to RGB per the direction bit
// ----------------------------------------------------------------------------
// usage:
//   input item: in_first/in_second/in_third with in_valid; taken when in_valid
//   is high and in_stall is low. result item: out_first/out_second/out_third
//   with out_valid; handed over when out_valid is high and out_stall is low.
//   cfg_we writes cfg_wdata into the direction bit (0 forward, 1 reverse);
//   write it only while the pipe is empty.
// timing:
//   six register stages, one item per cycle sustained while out_stall is
//   low. the depth is set by the hue and saturation dividers, two quotient
//   bits per stage over four stages.
// reset:
//   rst_n low empties the pipe and sets direction to forward.
// stall:
//   a stalled output holds its item; empty stages further back still fill,
//   and in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
`include "rgb_hsv_pixel_converter_unit_defines.svh"

module rgb_hsv_pixel_converter_unit import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_first,
  input  logic [PIX_W-1:0] in_second,
  input  logic [PIX_W-1:0] in_third,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_first,
  output logic [PIX_W-1:0] out_second,
  output logic [PIX_W-1:0] out_third
);

  localparam int NPL = 5;
  localparam int NST = NPL + 1;
  localparam int FRAC_MUL = 8739;
  localparam int FRAC_SH  = 10;

  logic           dir_r;
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  pl_t            st_r   [NPL];
  pl_t            st_nxt [NPL];
  out_t           out_r;
  out_t           out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
    end
  end

  rhc_prep u_prep (
    .dir_i    (dir_r),
    .first_i  (in_first),
    .second_i (in_second),
    .third_i  (in_third),
    .pl_o     (st_nxt[0])
  );

  // a stage may load when it is empty or its item moves on
  assign en[NST-1] = !v_r[NST-1] || !out_stall;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_stall = !en[0];

  for (genvar k = 1; k < NPL; k++) begin : g_stage
    localparam int BH = 9 - 2 * k;
    localparam int BL = 8 - 2 * k;
    div_t             h_d;
    div_t             s_d;
    logic [18:0]      fprod;
    logic [15:0]      pprod;
    logic [PIX_W-1:0] lo;

    rhc_div_step u_hdiv (
      .div_i  (st_r[k-1].hdv),
      .den_i  (st_r[k-1].hd),
      .bits_i ({st_r[k-1].hn[BH], st_r[k-1].hn[BL]}),
      .div_o  (h_d)
    );

    rhc_div_step u_sdiv (
      .div_i  (st_r[k-1].sdv),
      .den_i  (st_r[k-1].sd),
      .bits_i ({st_r[k-1].sn[BH], st_r[k-1].sn[BL]}),
      .div_o  (s_d)
    );

    always_comb begin
      fprod = 19'(st_r[k-1].rem30) * 19'(FRAC_MUL);
      pprod = 16'(st_r[k-1].vs) * 16'(st_r[k-1].f);
      lo    = st_r[k-1].val - st_r[k-1].vs;
      st_nxt[k]     = st_r[k-1];
      st_nxt[k].hdv = h_d;
      st_nxt[k].sdv = s_d;
      if (k == 1) begin
        // floor(256*rem/30) via a slightly high reciprocal
        st_nxt[k].f = 8'(fprod >> FRAC_SH);
      end
      if (k == 2) begin
        st_nxt[k].part = pprod[15:8];
      end
      if (k == 3) begin
        st_nxt[k].rr = st_r[k-1].val;
        st_nxt[k].gg = st_r[k-1].val;
        st_nxt[k].bb = st_r[k-1].val;
        if (!st_r[k-1].sat0 && st_r[k-1].sector < SECT_CNT) begin
          case (st_r[k-1].sector)
            4'd0: begin
              st_nxt[k].bb = lo;
              st_nxt[k].gg = lo + st_r[k-1].part;
            end
            4'd1: begin
              st_nxt[k].rr = st_r[k-1].val - st_r[k-1].part;
              st_nxt[k].bb = lo;
            end
            4'd2: begin
              st_nxt[k].rr = lo;
              st_nxt[k].bb = lo + st_r[k-1].part;
            end
            4'd3: begin
              st_nxt[k].rr = lo;
              st_nxt[k].gg = st_r[k-1].val - st_r[k-1].part;
            end
            4'd4: begin
              st_nxt[k].gg = lo;
              st_nxt[k].rr = lo + st_r[k-1].part;
            end
            4'd5: begin
              st_nxt[k].gg = lo;
              st_nxt[k].bb = st_r[k-1].val - st_r[k-1].part;
            end
            default: begin
              st_nxt[k].rr = st_r[k-1].val;
            end
          endcase
        end
      end
    end
  end

  rhc_finish u_fin (
    .pl_i  (st_r[NPL-1]),
    .out_o (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) st_r[0] <= st_nxt[0];
    for (int k = 1; k < NPL; k++) begin
      if (en[k] && v_r[k-1]) st_r[k] <= st_nxt[k];
    end
    if (en[NPL] && v_r[NPL-1]) out_r <= out_nxt;
  end

  assign out_valid  = v_r[NST-1];
  assign out_first  = out_r.first;
  assign out_second = out_r.second;
  assign out_third  = out_r.third;

  `RHC_CHECK(a_full_stalls, (v_r == '1) && out_stall, in_stall, "full pipe not stalling input")
  `RHC_CHECK_NEXT(a_stage_holds, v_r[1] && !en[1], v_r[1] && $stable(st_r[1].hdv), "stalled stage lost its item")
  `RHC_CHECK(a_hue_range, out_valid && !out_r.dir, out_first < HUE_HALF_MAX, "forward hue out of range")
  `RHC_CHECK(a_div_rem, v_r[2] && !st_r[2].dir && !st_r[2].gray, st_r[2].hdv.rem < st_r[2].hd, "hue divider remainder not below divisor")

endmodule

### hdl/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep
// first stage logic: channel max/min and divider setup, or hue sector split
// ----------------------------------------------------------------------------
module rhc_prep import rhc_pkg::*; (
  input  logic             dir_i,
  input  logic [PIX_W-1:0] first_i,
  input  logic [PIX_W-1:0] second_i,
  input  logic [PIX_W-1:0] third_i,
  output pl_t              pl_o
);

  logic [PIX_W-1:0] mx, mn, diff, mag;
  logic signed [8:0] x;
  logic [3:0]       cnt;
  logic [PIX_W-1:0] sect_base;
  logic [15:0]      vprod;

  always_comb begin
    mx = first_i;
    mn = first_i;
    if (second_i > mx) mx = second_i;
    if (third_i > mx) mx = third_i;
    if (second_i < mn) mn = second_i;
    if (third_i < mn) mn = third_i;
    diff = mx - mn;
  end

  // signed channel difference for the hue numerator
  always_comb begin
    if (mn == third_i) begin
      x = $signed({1'b0, second_i}) - $signed({1'b0, first_i});
    end else if (mn == first_i) begin
      x = $signed({1'b0, third_i}) - $signed({1'b0, second_i});
    end else begin
      x = $signed({1'b0, first_i}) - $signed({1'b0, third_i});
    end
    mag = x[8] ? 8'(-x) : x[7:0];
  end

  // sector count from independent threshold compares
  always_comb begin
    cnt = '0;
    for (int i = 1; i <= 8; i++) begin
      cnt = cnt + 4'(first_i >= 8'(SECT_W * i));
    end
    sect_base = 8'(cnt * 8'(SECT_W));
    vprod = 16'(third_i) * 16'(second_i);
  end

  always_comb begin
    pl_o        = '0;
    pl_o.dir    = dir_i;
    pl_o.gray   = (diff == '0);
    if (mn == third_i) begin
      pl_o.hsel = HSEL_B;
    end else if (mn == first_i) begin
      pl_o.hsel = HSEL_R;
    end else begin
      pl_o.hsel = HSEL_G;
    end
    pl_o.neg    = x[8];
    pl_o.mx     = mx;
    pl_o.hn     = 16'(mag) * 16'd60;
    pl_o.sn     = {diff, 8'h00} - 16'(diff);
    pl_o.hd     = diff;
    pl_o.sd     = mx;
    // quotients fit 8 bits, so the top byte is already below the divisor
    pl_o.hdv.rem = pl_o.hn[15:8];
    pl_o.sdv.rem = pl_o.sn[15:8];
    pl_o.sector = cnt;
    pl_o.rem30  = 5'(first_i - sect_base);
    pl_o.sat0   = (second_i == '0);
    pl_o.val    = third_i;
    pl_o.vs     = vprod[15:8];
  end

endmodule

### hdl/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step
// two restoring division steps, one quotient bit each
// ----------------------------------------------------------------------------
module rhc_div_step import rhc_pkg::*; (
  input  div_t             div_i,
  input  logic [PIX_W-1:0] den_i,
  input  logic [1:0]       bits_i,
  output div_t             div_o
);

  logic [PIX_W:0]   t1, t2;
  logic [PIX_W-1:0] r1, r2;
  logic             b1, b2;

  always_comb begin
    t1 = {div_i.rem, bits_i[1]};
    b1 = (t1 >= {1'b0, den_i});
    r1 = b1 ? 8'(t1 - {1'b0, den_i}) : t1[PIX_W-1:0];
    t2 = {r1, bits_i[0]};
    b2 = (t2 >= {1'b0, den_i});
    r2 = b2 ? 8'(t2 - {1'b0, den_i}) : t2[PIX_W-1:0];
    div_o.rem = r2;
    div_o.q   = {div_i.q[PIX_W-3:0], b1, b2};
  end

endmodule

### hdl/rhc_finish.sv
// ----------------------------------------------------------------------------
// rhc_finish
// last stage logic: signed hue, wrap and halve, then output select
// ----------------------------------------------------------------------------
module rhc_finish import rhc_pkg::*; (
  input  pl_t  pl_i,
  output out_t out_o
);

  logic [9:0]        base;
  logic signed [10:0] h;
  logic [9:0]        hw;

  always_comb begin
    case (pl_i.hsel)
      HSEL_B:  base = HUE_BASE_B;
      HSEL_R:  base = HUE_BASE_R;
      HSEL_G:  base = HUE_BASE_G;
      default: base = HUE_BASE_B;
    endcase
    // quotient truncated toward zero, sign applied afterwards
    if (pl_i.neg) begin
      h = $signed({1'b0, base}) - $signed({3'b000, pl_i.hdv.q});
    end else begin
      h = $signed({1'b0, base}) + $signed({3'b000, pl_i.hdv.q});
    end
    if (h < 0) begin
      hw = 10'(h + $signed({1'b0, HUE_FULL}));
    end else if (h >= $signed({1'b0, HUE_FULL})) begin
      hw = 10'(h - $signed({1'b0, HUE_FULL}));
    end else begin
      hw = h[9:0];
    end
  end

  always_comb begin
    out_o.dir = pl_i.dir;
    if (!pl_i.dir) begin
      out_o.first  = pl_i.gray ? '0 : hw[8:1];
      out_o.second = pl_i.gray ? '0 : pl_i.sdv.q;
      out_o.third  = pl_i.mx;
    end else begin
      out_o.first  = pl_i.rr;
      out_o.second = pl_i.gg;
      out_o.third  = pl_i.bb;
    end
  end

endmodule

### bench/rgb_hsv_pixel_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_hsv_pixel_converter_unit_tb
// drives pixels through the converter in both directions with random gaps and
// output stalls, predicts every result and checks it field by field
// ----------------------------------------------------------------------------
module rgb_hsv_pixel_converter_unit_tb import rhc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;
  localparam int PIPE_DEPTH = 6;
  localparam int LONG_HOLD = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 235;

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic [PIX_W-1:0] third;
  } pix_t;

  class hsv_scoreboard;
    pix_t pending_pixels[$];
    logic dir;
    int   mismatches;

    function new();
      dir = DIR_FWD;
      mismatches = 0;
    endfunction

    function pix_t convert_pixel(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                 logic [PIX_W-1:0] c);
      int   r, g, bl, mx, mn, diff, h, s;
      int   hue, sat, val, sector, f, vs, part;
      pix_t p;
      if (dir == DIR_FWD) begin
        r = int'(a);
        g = int'(b);
        bl = int'(c);
        mx = (r > g) ? r : g;
        if (bl > mx) mx = bl;
        mn = (r < g) ? r : g;
        if (bl < mn) mn = bl;
        diff = mx - mn;
        h = 0;
        s = 0;
        if (diff != 0) begin
          // int division truncates toward zero, which the hue needs
          if (mn == bl) h = (60 * (g - r)) / diff + 60;
          else if (mn == r) h = (60 * (bl - g)) / diff + 180;
          else h = (60 * (r - bl)) / diff + 300;
          if (h < 0) h += 360;
          else if (h >= 360) h -= 360;
          s = (255 * diff) / mx;
        end
        p.first = 8'(h >> 1);
        p.second = 8'(s);
        p.third = 8'(mx);
      end else begin
        hue = int'(a);
        sat = int'(b);
        val = int'(c);
        r = val;
        g = val;
        bl = val;
        if (sat > 0) begin
          sector = hue / 30;
          f = (256 * (hue % 30)) / 30;
          vs = (val * sat) >> 8;
          part = (vs * f) >> 8;
          // sector 6 and up leaves the pixel gray
          case (sector)
            0: begin bl = val - vs; g = bl + part; end
            1: begin r = val - part; bl = val - vs; end
            2: begin r = val - vs; bl = r + part; end
            3: begin r = val - vs; g = val - part; end
            4: begin g = val - vs; r = g + part; end
            5: begin g = val - vs; bl = val - part; end
            default: ;
          endcase
        end
        p.first = 8'(r);
        p.second = 8'(g);
        p.third = 8'(bl);
      end
      return p;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                             logic [PIX_W-1:0] c);
      pending_pixels.push_back(convert_pixel(a, b, c));
    endfunction

    function void check_pixel(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                              logic [PIX_W-1:0] c);
      pix_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, a, b, c);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      if (a !== want.first) begin
        $display("%0t: out_first expected %0d actual %0d", $time, want.first, a);
        mismatches++;
      end
      if (b !== want.second) begin
        $display("%0t: out_second expected %0d actual %0d", $time, want.second, b);
        mismatches++;
      end
      if (c !== want.third) begin
        $display("%0t: out_third expected %0d actual %0d", $time, want.third, c);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_first;
  logic [PIX_W-1:0] in_second;
  logic [PIX_W-1:0] in_third;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] out_first;
  logic [PIX_W-1:0] out_second;
  logic [PIX_W-1:0] out_third;

  hsv_scoreboard sb;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;

  rgb_hsv_pixel_converter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_first   (in_first),
    .in_second  (in_second),
    .in_third   (in_third),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // handshakes are seen with the values held just before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_first, in_second, in_third);
      if (out_valid && !out_stall) sb.check_pixel(out_first, out_second, out_third);
    end
  end

  // receiver: random stall bursts, plus one long hold to back up the pipe
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                            input logic [PIX_W-1:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first <= a;
    in_second <= b;
    in_third <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.dir = d;
  endtask

  task automatic send_random(input logic d);
    logic [PIX_W-1:0] a, b, c;
    int pick;
    pick = int'($urandom_range(0, 9));
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    if (d == DIR_FWD) begin
      // some gray pixels and channel ties among the plain colors
      if (pick == 0) begin
        b = a;
        c = a;
      end else if (pick == 1) begin
        c = b;
      end else if (pick == 2) begin
        b = a;
      end
    end else begin
      // mostly valid hues, some out of range; now and then no saturation
      if (pick != 0) a = 8'($urandom_range(0, 179));
      if ($urandom_range(0, 15) == 0) b = '0;
    end
    send_pixel(a, b, c);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_first = '0;
    in_second = '0;
    in_third = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_direction(DIR_FWD);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd10, 8'd5, 8'd5);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd253);

    write_direction(DIR_REV);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd29, 8'd255, 8'd255);
    send_pixel(8'd30, 8'd200, 8'd255);
    send_pixel(8'd89, 8'd255, 8'd128);
    send_pixel(8'd120, 8'd255, 8'd255);
    send_pixel(8'd150, 8'd255, 8'd255);
    send_pixel(8'd179, 8'd255, 8'd255);
    send_pixel(8'd180, 8'd255, 8'd77);
    send_pixel(8'd255, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd0, 8'd200);
    send_pixel(8'd45, 8'd1, 8'd255);
    send_pixel(8'd170, 8'd128, 8'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase < PHASES - 1);
      write_direction(phase[0] ? DIR_FWD : DIR_REV);
      if (phase == 2) long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 4 && i == PHASE_ITEMS / 2) wait_drained();
        send_random(sb.dir);
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
